// ----- rtl/pcc_pkg.sv -----
package pcc_pkg;

  localparam int NUM_POINTS = 9;
  localparam int PT_IDX_W   = $clog2(NUM_POINTS);
  localparam int TUNE_REGS  = 3;
  localparam int TUNES_PER_REG = 3;

  localparam int PITCH_W = 17;
  localparam int FRAC_W  = 12;
  localparam int PT_W    = 16;
  localparam int EFF_W   = 13;
  localparam int SLOPE_W = 13;
  localparam int CORR_W  = 16;
  localparam int CFG_W   = 48;
  localparam int CFG_IDX_W = 3;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 40;
  localparam int OUT_USED_W = 2 * PITCH_W + 1;

  // interpolation weights and products
  localparam int WA_W   = FRAC_W + 1;
  localparam int WB_W   = PITCH_W;
  localparam int CNUM_W = SLOPE_W + WB_W + 1;

  // round(cnum / 3072), with 3072 = 1024 * 3: bias, shift, then reciprocal of 3
  localparam int SHIFT_HALF  = 1536;
  localparam int SHIFT_BIAS_Q = 1 << 18;
  localparam int SHIFT_BIAS  = 3072 * SHIFT_BIAS_Q;
  localparam int Y_LSB       = 10;
  localparam int Y_W         = 21;
  localparam int RECIP_SHIFT = 21;
  localparam int RECIP3      = ((1 << RECIP_SHIFT) + 1) / 3;
  localparam int MUL_W       = Y_W + RECIP_SHIFT;
  localparam int Q_W         = MUL_W - RECIP_SHIFT;
  localparam int SHIFT_W     = Q_W + 1;
  localparam int SUM_W       = SHIFT_W + 1;

  localparam int POINT_LIMIT = 3072;
  localparam int OUT_LIMIT   = 40960;
  localparam int PT_MAX      = (1 << (PT_W - 1)) - 1;
  localparam int PT_MIN      = -(1 << (PT_W - 1));
  localparam int CORR_MAX    = (1 << (CORR_W - 1)) - 1;
  localparam int CORR_MIN    = -(1 << (CORR_W - 1));

  localparam logic signed [PITCH_W-1:0] TOP_VOLT = PITCH_W'((NUM_POINTS - 1) << FRAC_W);
  localparam logic [WA_W-1:0] ONE_VOLT_W = WA_W'(1 << FRAC_W);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TUNE_LO    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TUNE_MID   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TUNE_HI    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_SLOPE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_SLOPE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_NUDGE_STEP = 3'd5;

  localparam logic signed [SLOPE_W-1:0] NUDGE_STEP_RESET = SLOPE_W'(256);

  typedef logic signed [PT_W-1:0] point_t;
  typedef point_t [NUM_POINTS-1:0] point_vec_t;

  typedef struct packed {
    logic signed [PITCH_W-1:0] pitch;
    logic nudge_up;
    logic nudge_down;
    logic clear_here;
    logic clear_every;
    logic selected;
  } sample_t;

  typedef struct packed {
    point_vec_t tune;
    logic signed [SLOPE_W-1:0] low_slope;
    logic signed [SLOPE_W-1:0] high_slope;
    logic signed [SLOPE_W-1:0] step;
  } cfg_t;

  typedef struct packed {
    logic signed [EFF_W-1:0]   ea;
    logic [WA_W-1:0]           wa;
    logic signed [SLOPE_W-1:0] eb;
    logic [WB_W-1:0]           wb;
    logic signed [PITCH_W-1:0] pitch;
    logic                      selected;
  } terms_t;

  typedef struct packed {
    logic [MUL_W-1:0]          prod;
    logic signed [CORR_W-1:0]  corr;
    logic                      pos;
    logic                      neg;
    logic signed [PITCH_W-1:0] pitch;
    logic                      selected;
  } scaled_t;

  function automatic point_t sat_point(input logic signed [PT_W:0] v);
    if (v > PT_MAX) return PT_W'(PT_MAX);
    else if (v < PT_MIN) return PT_W'(PT_MIN);
    else return PT_W'(v);
  endfunction

  function automatic logic signed [EFF_W-1:0] clamp_eff(input logic signed [PT_W:0] v);
    if (v > POINT_LIMIT) return EFF_W'(POINT_LIMIT);
    else if (v < -POINT_LIMIT) return EFF_W'(-POINT_LIMIT);
    else return EFF_W'(v);
  endfunction

endpackage

// ----- rtl/pcc_points.sv -----
module pcc_points import pcc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    fire,
  input  sample_t sample,
  input  cfg_t    cfg,
  output terms_t  terms
);

  point_vec_t offsets;
  point_vec_t offsets_next;
  logic [3:0] gate_hist;
  logic [3:0] lev;
  logic [3:0] rise;
  logic up;
  logic down;
  logic zero_adj;
  logic [PT_IDX_W-1:0] lo_idx;
  logic [PT_IDX_W-1:0] hi_idx;
  logic [FRAC_W-1:0] frac;
  logic signed [EFF_W-1:0] eff [NUM_POINTS];
  terms_t terms_next;

  assign lev  = {sample.clear_every, sample.clear_here, sample.nudge_down, sample.nudge_up};
  assign rise = lev & ~gate_hist;
  assign up   = rise[0];
  assign down = rise[1];
  assign zero_adj = (up && down) || rise[2];
  assign frac = sample.pitch[FRAC_W-1:0];

  // adjacent points
  always_comb begin
    if (sample.pitch <= 0) begin
      lo_idx = '0;
      hi_idx = '0;
    end else if (sample.pitch >= TOP_VOLT) begin
      lo_idx = PT_IDX_W'(NUM_POINTS - 1);
      hi_idx = PT_IDX_W'(NUM_POINTS - 1);
    end else begin
      lo_idx = sample.pitch[FRAC_W+PT_IDX_W-1:FRAC_W];
      hi_idx = (frac == '0) ? lo_idx : lo_idx + 1'b1;
    end
  end

  // one edit lane per point, then its effective value
  always_comb begin
    point_t base;
    logic adj;
    logic signed [SLOPE_W:0] amt;
    logic signed [PT_W:0] sum;
    for (int k = 0; k < NUM_POINTS; k++) begin
      base = rise[3] ? '0 : offsets[k];
      adj  = sample.selected && (lo_idx == PT_IDX_W'(k) || hi_idx == PT_IDX_W'(k));
      amt  = up ? (SLOPE_W+1)'(cfg.step) : -((SLOPE_W+1)'(cfg.step));
      sum  = (PT_W+1)'(base) + (PT_W+1)'(amt);
      if (adj && zero_adj) offsets_next[k] = '0;
      else if (adj && (up || down)) offsets_next[k] = sat_point(sum);
      else offsets_next[k] = base;
      eff[k] = clamp_eff((PT_W+1)'(offsets_next[k]) + (PT_W+1)'(cfg.tune[k]));
    end
  end

  always_comb begin
    terms_next.pitch    = sample.pitch;
    terms_next.selected = sample.selected;
    terms_next.ea       = eff[lo_idx];
    if (sample.pitch < 0) begin
      terms_next.wa = ONE_VOLT_W;
      terms_next.eb = cfg.low_slope;
      terms_next.wb = WB_W'(-((PITCH_W+1)'(sample.pitch)));
    end else if (sample.pitch > TOP_VOLT) begin
      terms_next.wa = ONE_VOLT_W;
      terms_next.eb = cfg.high_slope;
      terms_next.wb = WB_W'(unsigned'(sample.pitch - TOP_VOLT));
    end else begin
      terms_next.wa = ONE_VOLT_W - WA_W'(frac);
      terms_next.eb = eff[hi_idx];
      terms_next.wb = WB_W'(frac);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      offsets   <= '0;
      gate_hist <= '0;
    end else if (fire) begin
      offsets   <= offsets_next;
      gate_hist <= lev;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      terms <= terms_next;
    end
  end

endmodule

// ----- rtl/pcc_curve.sv -----
module pcc_curve import pcc_pkg::*; (
  input  logic    clk,
  input  logic    load_b,
  input  logic    load_c,
  input  terms_t  terms,
  output scaled_t scaled
);

  logic signed [EFF_W+WA_W:0]   prod_a;
  logic signed [CNUM_W-1:0]     prod_b;
  logic signed [CNUM_W-1:0]     cnum;
  logic signed [PITCH_W-1:0]    pitch_b;
  logic                         sel_b;
  logic signed [CNUM_W:0]       rounded;
  logic signed [CNUM_W-FRAC_W:0] corr_wide;
  logic signed [CNUM_W:0]       biased;
  logic [Y_W-1:0]               y;
  logic signed [CORR_W-1:0]     corr_sat;

  assign prod_a = terms.ea * $signed({1'b0, terms.wa});
  assign prod_b = terms.eb * $signed({1'b0, terms.wb});

  always_ff @(posedge clk) begin
    if (load_b) begin
      cnum    <= CNUM_W'(prod_a) + prod_b;
      pitch_b <= terms.pitch;
      sel_b   <= terms.selected;
    end
  end

  // correction in 1/256 semitone, halves round up
  assign rounded   = (CNUM_W+1)'(cnum) + (CNUM_W+1)'(1 << (FRAC_W - 1));
  assign corr_wide = $signed(rounded[CNUM_W:FRAC_W]);

  always_comb begin
    if (corr_wide > CORR_MAX) corr_sat = CORR_W'(CORR_MAX);
    else if (corr_wide < CORR_MIN) corr_sat = CORR_W'(CORR_MIN);
    else corr_sat = CORR_W'(corr_wide);
  end

  // biased to stay positive, then floor by 1024 and by 3
  assign biased = (CNUM_W+1)'(cnum) + (CNUM_W+1)'(SHIFT_BIAS + SHIFT_HALF);
  assign y      = biased[Y_LSB+Y_W-1:Y_LSB];

  always_ff @(posedge clk) begin
    if (load_c) begin
      scaled.prod     <= MUL_W'(y) * MUL_W'(RECIP3);
      scaled.corr     <= corr_sat;
      scaled.pos      <= cnum > 0;
      scaled.neg      <= cnum < 0;
      scaled.pitch    <= pitch_b;
      scaled.selected <= sel_b;
    end
  end

endmodule

// ----- rtl/pitch_calibration_curve_core.sv -----
// pitch calibration curve, one sample per clock while the output is not stalled
// a sample passes the sample_q, terms, cnum, scaled and output registers in order
// throughput: one sample per cycle when not stalled; five register stages with a stall that
// ripples back only through full stages
// reset (synchronous): points, gate history, lamps and valids clear,
// tunes and slopes go to zero, nudge step to 256
module pitch_calibration_curve_core import pcc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // pitch[16:0], nudge_up, nudge_down, clear_here, clear_every, selected, zero pad
  input  logic [IN_DATA_W-1:0]  s_tdata,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // corrected_pitch[16:0], correction_amount[15:0], lamp_up, lamp_down, zero pad
  output logic [OUT_DATA_W-1:0] m_tdata
);

  logic [CFG_W-1:0] tune_words [TUNE_REGS];
  logic signed [SLOPE_W-1:0] low_slope;
  logic signed [SLOPE_W-1:0] high_slope;
  logic signed [SLOPE_W-1:0] nudge_step;
  cfg_t cfg;

  logic v0, v1, v2, v3, v4;
  logic rdy0, rdy1, rdy2, rdy3, rdy4;
  sample_t sample_in;
  sample_t sample_q;
  terms_t  terms;
  scaled_t scaled;

  logic [Q_W-1:0]            quot;
  logic signed [SHIFT_W-1:0] shift;
  logic signed [SUM_W-1:0]   sum;
  logic signed [PITCH_W-1:0] corrected_q;
  logic signed [CORR_W-1:0]  corr_q;
  logic lamp_up;
  logic lamp_down;
  logic lamp_load;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < TUNE_REGS; r++) tune_words[r] <= '0;
      low_slope  <= '0;
      high_slope <= '0;
      nudge_step <= NUDGE_STEP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TUNE_LO:    tune_words[0] <= cfg_data;
        REG_TUNE_MID:   tune_words[1] <= cfg_data;
        REG_TUNE_HI:    tune_words[2] <= cfg_data;
        REG_LOW_SLOPE:  low_slope  <= SLOPE_W'(cfg_data);
        REG_HIGH_SLOPE: high_slope <= SLOPE_W'(cfg_data);
        REG_NUDGE_STEP: nudge_step <= SLOPE_W'(cfg_data);
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int r = 0; r < TUNE_REGS; r++) begin
      for (int i = 0; i < TUNES_PER_REG; i++) begin
        cfg.tune[TUNES_PER_REG*r+i] = tune_words[r][i*PT_W +: PT_W];
      end
    end
    cfg.low_slope  = low_slope;
    cfg.high_slope = high_slope;
    cfg.step       = nudge_step;
  end

  // stage flow control
  assign rdy4 = !v4 || m_tready;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign rdy0 = !v0 || rdy1;
  assign s_tready = rdy0;
  assign m_tvalid = v4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy0) v0 <= s_tvalid;
      if (rdy1) v1 <= v0;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
    end
  end

  assign sample_in.pitch       = $signed(s_tdata[PITCH_W-1:0]);
  assign sample_in.nudge_up    = s_tdata[PITCH_W];
  assign sample_in.nudge_down  = s_tdata[PITCH_W+1];
  assign sample_in.clear_here  = s_tdata[PITCH_W+2];
  assign sample_in.clear_every = s_tdata[PITCH_W+3];
  assign sample_in.selected    = s_tdata[PITCH_W+4];

  always_ff @(posedge clk) begin
    if (rdy0 && s_tvalid) begin
      sample_q <= sample_in;
    end
  end

  pcc_points u_points (
    .clk    (clk),
    .rst    (rst),
    .fire   (rdy1 && v0),
    .sample (sample_q),
    .cfg    (cfg),
    .terms  (terms)
  );

  pcc_curve u_curve (
    .clk    (clk),
    .load_b (rdy2 && v1),
    .load_c (rdy3 && v2),
    .terms  (terms),
    .scaled (scaled)
  );

  // output stage: pitch shift and saturation
  assign quot  = scaled.prod[MUL_W-1:RECIP_SHIFT];
  assign shift = $signed({1'b0, quot}) - SHIFT_W'(SHIFT_BIAS_Q);
  assign sum   = SUM_W'(scaled.pitch) + SUM_W'(shift);
  assign lamp_load = rdy4 && v3 && scaled.selected;

  always_ff @(posedge clk) begin
    if (rdy4 && v3) begin
      if (sum > OUT_LIMIT) corrected_q <= PITCH_W'(OUT_LIMIT);
      else if (sum < -OUT_LIMIT) corrected_q <= PITCH_W'(-OUT_LIMIT);
      else corrected_q <= PITCH_W'(sum);
      corr_q <= scaled.corr;
    end
  end

  // lamps hold until a selected sample passes
  always_ff @(posedge clk) begin
    if (rst) begin
      lamp_up   <= 1'b0;
      lamp_down <= 1'b0;
    end else if (lamp_load) begin
      lamp_up   <= scaled.pos;
      lamp_down <= scaled.neg;
    end
  end

  assign m_tdata = {(OUT_DATA_W - OUT_USED_W)'(0), lamp_down, lamp_up, corr_q, corrected_q};

  a_lamps_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(lamp_up && lamp_down))
    else $error("both lamps lit");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (m_tvalid && !m_tready && v0 && v1 && v2 && v3))
    else $error("input stalled while a stage is free");

  a_lamps_change_on_load: assert property (@(posedge clk) disable iff (rst)
    (lamp_up != $past(lamp_up) || lamp_down != $past(lamp_down)) |-> $past(lamp_load))
    else $error("lamps changed without a selected sample");

endmodule

// ----- tb/testbench.sv -----
module testbench;
  import pcc_pkg::*;

  localparam int CYCLE_LIMIT     = 200000;
  localparam int DRAIN_CYCLES    = 20;
  localparam int RANDOM_PHASES   = 8;
  localparam int ITEMS_PER_PHASE = 56;
  localparam int MAX_GAP         = 13;
  localparam int ONE_V           = 1 << FRAC_W;
  // volt lsbs per 1/256 semitone, scaled by one volt: 256 * 12
  localparam int SHIFT_DIV       = 256 * 12;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

  // gate bits of a directed row
  localparam bit [4:0] G_NONE  = 5'b00000;
  localparam bit [4:0] G_UP    = 5'b00001;
  localparam bit [4:0] G_DOWN  = 5'b00010;
  localparam bit [4:0] G_HERE  = 5'b00100;
  localparam bit [4:0] G_EVERY = 5'b01000;
  localparam bit [4:0] G_SEL   = 5'b10000;

  typedef enum int {GATES_MIXED, GATES_PUSH_UP, GATES_PUSH_DOWN} gate_mode_t;

  typedef struct packed {
    logic signed [PITCH_W-1:0] pitch_out;
    logic signed [CORR_W-1:0]  amount;
    logic                      lamp_up;
    logic                      lamp_down;
  } result_t;

  typedef struct {
    bit      typed;
    result_t res;
  } answer_t;

  typedef struct {
    sample_t smp;
    answer_t ans;
  } row_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;
  logic s_tvalid;
  logic s_tready;
  logic [IN_DATA_W-1:0] s_tdata;
  logic m_tvalid;
  logic m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;

  pitch_calibration_curve_core u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #6 clk = ~clk;

  // shadow of the curve state and registers
  point_t stored_pt [NUM_POINTS];
  point_t tune_pt [NUM_POINTS];
  logic [3:0] prev_levels;
  logic [1:0] lamps;
  logic signed [SLOPE_W-1:0] slope_below;
  logic signed [SLOPE_W-1:0] slope_above;
  logic signed [SLOPE_W-1:0] step_amt;

  result_t awaited[$];
  answer_t typed_answers[$];
  row_t plan[$];

  int fail_count = 0;
  int cycle_count = 0;
  bit steady;
  int focus_volt;
  gate_mode_t gate_mode;
  sample_t last_gen;

  function automatic longint clip(longint x, longint lo, longint hi);
    return x < lo ? lo : (x > hi ? hi : x);
  endfunction

  // nearest, halves toward plus infinity
  function automatic longint round_near(longint n, longint d);
    longint x;
    longint q;
    x = n + d / 2;
    q = x / d;
    if ((x % d) != 0 && x < 0) q--;
    return q;
  endfunction

  function automatic longint point_value(int k);
    return clip(longint'(stored_pt[k]) + longint'(tune_pt[k]), -POINT_LIMIT, POINT_LIMIT);
  endfunction

  function automatic void neighbors(int p, output int lo, output int hi);
    if (p <= 0) begin
      lo = 0;
      hi = 0;
    end else if (p >= int'(TOP_VOLT)) begin
      lo = NUM_POINTS - 1;
      hi = NUM_POINTS - 1;
    end else begin
      lo = p / ONE_V;
      hi = (p % ONE_V == 0) ? lo : lo + 1;
    end
  endfunction

  // correction scaled by one volt
  function automatic longint curve_at(int p);
    int lo;
    int hi;
    longint f;
    if (p < 0)
      return point_value(0) * ONE_V + longint'(slope_below) * longint'(-p);
    if (p > int'(TOP_VOLT))
      return point_value(NUM_POINTS - 1) * ONE_V
           + longint'(slope_above) * longint'(p - int'(TOP_VOLT));
    neighbors(p, lo, hi);
    if (lo == hi) return point_value(lo) * ONE_V;
    f = p % ONE_V;
    return point_value(lo) * (ONE_V - f) + point_value(hi) * f;
  endfunction

  function automatic point_t nudged(point_t v, int amt);
    return point_t'(clip(longint'(v) + amt, PT_MIN, PT_MAX));
  endfunction

  function automatic void apply_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    case (idx)
      REG_TUNE_LO, REG_TUNE_MID, REG_TUNE_HI: begin
        for (int i = 0; i < TUNES_PER_REG; i++)
          tune_pt[int'(idx) * TUNES_PER_REG + i] = data[PT_W*i +: PT_W];
      end
      REG_LOW_SLOPE:  slope_below = data[SLOPE_W-1:0];
      REG_HIGH_SLOPE: slope_above = data[SLOPE_W-1:0];
      REG_NUDGE_STEP: step_amt = data[SLOPE_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic result_t predict_sample(sample_t smp);
    int p;
    int lo;
    int hi;
    int amt;
    logic [3:0] lev;
    logic [3:0] rise;
    longint cnum;
    result_t r;
    p = int'(smp.pitch);
    lev = {smp.clear_every, smp.clear_here, smp.nudge_down, smp.nudge_up};
    rise = lev & ~prev_levels;
    prev_levels = lev;
    if (rise[3]) begin
      for (int k = 0; k < NUM_POINTS; k++) stored_pt[k] = '0;
    end
    if (smp.selected) begin
      neighbors(p, lo, hi);
      if ((rise[0] && rise[1]) || rise[2]) begin
        stored_pt[lo] = '0;
        stored_pt[hi] = '0;
      end else if (rise[0] || rise[1]) begin
        amt = rise[0] ? int'(step_amt) : -int'(step_amt);
        stored_pt[lo] = nudged(stored_pt[lo], amt);
        if (hi != lo) stored_pt[hi] = nudged(stored_pt[hi], amt);
      end
    end
    cnum = curve_at(p);
    r.amount = CORR_W'(clip(round_near(cnum, ONE_V), CORR_MIN, CORR_MAX));
    r.pitch_out = PITCH_W'(clip(p + round_near(cnum, SHIFT_DIV), -OUT_LIMIT, OUT_LIMIT));
    if (smp.selected) lamps = {cnum < 0, cnum > 0};
    r.lamp_up = lamps[0];
    r.lamp_down = lamps[1];
    return r;
  endfunction

  function automatic logic [PT_W-1:0] pick_tune();
    case ($urandom_range(0, 4))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return PT_W'(int'($urandom_range(0, 1200)) - 600);
      3: return PT_W'($urandom);
      default: return PT_W'(int'($urandom_range(0, 2 * POINT_LIMIT)) - POINT_LIMIT);
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_tunes();
    return {pick_tune(), pick_tune(), pick_tune()};
  endfunction

  function automatic logic signed [SLOPE_W-1:0] pick_slope();
    case ($urandom_range(0, 5))
      0: return SLOPE_W'(POINT_LIMIT);
      1: return SLOPE_W'(-POINT_LIMIT);
      2: return SLOPE_W'($urandom);
      3: return '0;
      default: return SLOPE_W'(int'($urandom_range(0, 2 * POINT_LIMIT)) - POINT_LIMIT);
    endcase
  endfunction

  function automatic sample_t random_sample();
    int k;
    sample_t s;
    k = $urandom_range(0, NUM_POINTS - 1);
    case ($urandom_range(0, 9))
      0: s.pitch = PITCH_W'(k * ONE_V);
      1: s.pitch = PITCH_W'($urandom);
      2: s.pitch = PITCH_W'(int'($urandom_range(0, 2 * OUT_LIMIT)) - OUT_LIMIT);
      3: s.pitch = PITCH_W'(k * ONE_V + int'($urandom_range(0, 6)) - 3);
      4: s.pitch = PITCH_W'(-int'($urandom_range(0, 2 * ONE_V)));
      5: s.pitch = PITCH_W'(int'(TOP_VOLT) + int'($urandom_range(0, 2 * ONE_V)));
      default: s.pitch = PITCH_W'(focus_volt * ONE_V + int'($urandom_range(0, 2 * ONE_V)));
    endcase
    case (gate_mode)
      GATES_PUSH_UP, GATES_PUSH_DOWN: begin
        // toggle one gate so every other sample is an edge, mostly on one point
        s.nudge_up    = (gate_mode == GATES_PUSH_UP) ? ~last_gen.nudge_up : 1'b0;
        s.nudge_down  = (gate_mode == GATES_PUSH_DOWN) ? ~last_gen.nudge_down : 1'b0;
        s.clear_here  = 1'b0;
        s.clear_every = 1'b0;
        s.selected    = ($urandom_range(0, 7) != 0);
        if ($urandom_range(0, 3) != 0) s.pitch = PITCH_W'(focus_volt * ONE_V);
      end
      default: begin
        s.nudge_up    = 1'($urandom_range(0, 1));
        s.nudge_down  = 1'($urandom_range(0, 1));
        s.clear_here  = ($urandom_range(0, 7) == 0);
        s.clear_every = ($urandom_range(0, 23) == 0);
        s.selected    = ($urandom_range(0, 5) != 0);
      end
    endcase
    last_gen = s;
    return s;
  endfunction

  task automatic add_known(int pitch, bit [4:0] gates, int ep, int ec, bit eu, bit ed);
    row_t row;
    row.smp.pitch       = PITCH_W'(pitch);
    row.smp.nudge_up    = gates[0];
    row.smp.nudge_down  = gates[1];
    row.smp.clear_here  = gates[2];
    row.smp.clear_every = gates[3];
    row.smp.selected    = gates[4];
    row.ans.typed = 1'b1;
    row.ans.res.pitch_out = PITCH_W'(ep);
    row.ans.res.amount    = CORR_W'(ec);
    row.ans.res.lamp_up   = eu;
    row.ans.res.lamp_down = ed;
    plan.push_back(row);
  endtask

  task automatic add_row(int pitch, bit [4:0] gates);
    add_known(pitch, gates, 0, 0, 1'b0, 1'b0);
    plan[$].ans.typed = 1'b0;
  endtask

  task automatic send_item(sample_t smp, answer_t ans);
    int gap;
    gap = steady ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    typed_answers.push_back(ans);
    s_tdata <= {{(IN_DATA_W - PITCH_W - 5){1'b0}}, smp.selected, smp.clear_every,
                smp.clear_here, smp.nudge_down, smp.nudge_up, smp.pitch};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
  endtask

  // called in the step of the last input transfer
  task automatic settle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (awaited.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_we    <= 1'b1;
    @(posedge clk);
    apply_config(idx, data);
  endtask

  task automatic load_config(logic [CFG_W-1:0] lo, logic [CFG_W-1:0] mid,
                             logic [CFG_W-1:0] hi, logic signed [SLOPE_W-1:0] sl,
                             logic signed [SLOPE_W-1:0] sh,
                             logic signed [SLOPE_W-1:0] st, bit spare);
    write_reg(REG_TUNE_LO, lo);
    write_reg(REG_TUNE_MID, mid);
    write_reg(REG_TUNE_HI, hi);
    write_reg(REG_LOW_SLOPE, CFG_W'(sl));
    write_reg(REG_HIGH_SLOPE, CFG_W'(sh));
    write_reg(REG_NUDGE_STEP, CFG_W'(st));
    if (spare) begin
      // indexes past the register list must not disturb anything
      write_reg(REG_SPARE_6, CFG_W'({$urandom, $urandom}));
      write_reg(REG_SPARE_7, CFG_W'({$urandom, $urandom}));
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  always @(posedge clk) begin : watch
    result_t got;
    result_t want;
    sample_t seen;
    answer_t ans;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got.pitch_out = m_tdata[PITCH_W-1:0];
        got.amount    = m_tdata[PITCH_W +: CORR_W];
        got.lamp_up   = m_tdata[PITCH_W + CORR_W];
        got.lamp_down = m_tdata[PITCH_W + CORR_W + 1];
        if (awaited.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected output transfer: %h", m_tdata);
        end else begin
          want = awaited.pop_front();
          if (got.pitch_out !== want.pitch_out || got.amount !== want.amount ||
              got.lamp_up !== want.lamp_up || got.lamp_down !== want.lamp_down) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: pitch %0d/%0d amount %0d/%0d lamps %b%b/%b%b (exp/got)",
                       want.pitch_out, got.pitch_out, want.amount, got.amount,
                       want.lamp_up, want.lamp_down, got.lamp_up, got.lamp_down);
          end
        end
      end
      if (s_tvalid && s_tready) begin
        seen.pitch       = s_tdata[PITCH_W-1:0];
        seen.nudge_up    = s_tdata[PITCH_W];
        seen.nudge_down  = s_tdata[PITCH_W + 1];
        seen.clear_here  = s_tdata[PITCH_W + 2];
        seen.clear_every = s_tdata[PITCH_W + 3];
        seen.selected    = s_tdata[PITCH_W + 4];
        want = predict_sample(seen);
        if (typed_answers.size() != 0) begin
          ans = typed_answers.pop_front();
          if (ans.typed) want = ans.res;
        end
        awaited.push_back(want);
      end
    end
  end

  initial begin : sink
    int gap;
    @(posedge clk);
    forever begin
      gap = steady ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    answer_t none;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    for (int k = 0; k < NUM_POINTS; k++) begin
      stored_pt[k] = '0;
      tune_pt[k] = '0;
    end
    prev_levels = '0;
    lamps = '0;
    slope_below = '0;
    slope_above = '0;
    step_amt = NUDGE_STEP_RESET;
    steady = 1'b0;
    gate_mode = GATES_MIXED;
    focus_volt = 0;
    last_gen = '0;
    none.typed = 1'b0;
    none.res = '0;

    // flat curve after reset, then a nudge up and back down on point 0
    add_known(0, G_NONE, 0, 0, 1'b0, 1'b0);
    add_known(65535, G_NONE, OUT_LIMIT, 0, 1'b0, 1'b0);
    add_known(-65536, G_NONE, -OUT_LIMIT, 0, 1'b0, 1'b0);
    add_known(OUT_LIMIT, G_NONE, OUT_LIMIT, 0, 1'b0, 1'b0);
    add_known(-OUT_LIMIT, G_NONE, -OUT_LIMIT, 0, 1'b0, 1'b0);
    add_known(0, G_UP | G_SEL, 341, 256, 1'b1, 1'b0);
    add_known(0, G_UP | G_SEL, 341, 256, 1'b1, 1'b0);
    add_known(0, G_UP | G_DOWN | G_SEL, 0, 0, 1'b0, 1'b0);
    add_row(0, G_NONE);
    add_row(6144, G_UP | G_SEL);
    add_row(6144, G_NONE);
    add_row(6144, G_DOWN | G_SEL);
    add_row(8192, G_NONE);
    add_row(8192, G_UP | G_SEL);
    add_row(36000, G_NONE);
    add_row(36000, G_UP | G_SEL);
    add_row(-5000, G_NONE);
    add_row(-5000, G_DOWN | G_SEL);
    add_row(6144, G_NONE);
    add_row(6144, G_UP | G_DOWN | G_SEL);
    add_row(8192, G_HERE | G_SEL);
    add_row(12000, G_UP);
    add_row(20000, G_EVERY);
    add_row(32768, G_UP | G_SEL);
    add_row(4095, G_SEL);
    add_row(1, G_SEL);

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) send_item(plan[i].smp, plan[i].ans);
    settle();

    for (int ph = 1; ph <= RANDOM_PHASES; ph++) begin
      case (ph)
        1: load_config(pick_tunes(), pick_tunes(), pick_tunes(),
                       pick_slope(), pick_slope(), pick_slope(), 1'b1);
        2: load_config({16'h0C00, 16'h8000, 16'h7FFF}, {16'hF400, 16'h0000, 16'h7FFF},
                       {16'h8000, 16'h0C00, 16'hF401}, SLOPE_W'(POINT_LIMIT),
                       SLOPE_W'(-POINT_LIMIT), SLOPE_W'(POINT_LIMIT), 1'b0);
        3: load_config('0, '0, '0, SLOPE_W'(-POINT_LIMIT), SLOPE_W'(POINT_LIMIT),
                       SLOPE_W'(-POINT_LIMIT), 1'b0);
        4: load_config(CFG_W'({$urandom, $urandom}), CFG_W'({$urandom, $urandom}),
                       CFG_W'({$urandom, $urandom}), 13'h1000, 13'h0FFF, 13'h1000, 1'b1);
        default: load_config(pick_tunes(), pick_tunes(), pick_tunes(),
                             pick_slope(), pick_slope(), pick_slope(), ph[0]);
      endcase
      case (ph)
        2, 3: gate_mode = GATES_PUSH_UP;
        6: gate_mode = GATES_PUSH_DOWN;
        default: gate_mode = GATES_MIXED;
      endcase
      steady = (ph % 3 == 0);
      focus_volt = $urandom_range(0, NUM_POINTS - 3);
      repeat (ITEMS_PER_PHASE) send_item(random_sample(), none);
      settle();
    end

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/pcc_pkg.sv
rtl/pcc_points.sv
rtl/pcc_curve.sv
rtl/pitch_calibration_curve_core.sv
tb/testbench.sv
